// ----- hw/rtl/tmw_pkg.sv -----
// Shared types and constants of the text mode terminal writer.
// No dependencies; the core refers to it by scoped names.
package tmw_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [15:0] RESET_CELL = 16'h0720;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_RESP
    } t_state;

endpackage

// ----- hw/rtl/tmw_if.sv -----
// Request and response channel interfaces of the text mode terminal writer.
// Depends on nothing; used by the top level ports.
interface tmw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, func, char_code, read_row, read_col, input ready);
    modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

interface tmw_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic [15:0] cell_word;

    modport source (output valid, cursor_row, cursor_col, scrolled, cell_word, input ready);
    modport sink   (input valid, cursor_row, cursor_col, scrolled, cell_word, output ready);
endinterface

// ----- hw/rtl/text_mode_terminal_writer_core.sv -----
// Text mode terminal writer: screen memory of ROWS x COLUMNS cells plus cursor.
// Depends on tmw_pkg and the channel interfaces in tmw_if.sv.
//
// Every request gives one response. All screen traffic goes through one
// memory with one write port and one read port, read data registered, so the
// write port sets the timing. A put that wraps past the last row scrolls:
// one copy per cell of the upper rows, then one blank per cell of the last
// row. A clear writes every cell once. After reset a clearing pass fills the
// screen with 0x0720 before the first request is taken; text_color writes are
// taken meanwhile.
// One request is worked on at a time; a request is taken while the previous
// response still waits in the output register.
module text_mode_terminal_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    tmw_req_if.sink         i_req,
    tmw_rsp_if.source       o_rsp
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int SCROLL_N = COLUMNS * (ROWS - 1);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);

    tmw_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [7:0]        r_color;
    logic              r_res_scr, n_res_scr;
    logic [15:0]       r_res_cell, n_res_cell;

    logic              r_ov;
    logic [4:0]        r_o_row;
    logic [6:0]        r_o_col;
    logic              r_o_scr;
    logic [15:0]       r_o_cell;

    logic [15:0]       mem [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic              req_acc, out_load;
    logic              rd_in_range, col_last, row_last;
    logic [ADDR_W-1:0] cur_addr, rd_addr;
    logic [ROW_W+4:0]  row_ext;
    logic [COL_W+6:0]  col_ext;
    logic [31:0]       cur_lin, rd_lin;

    assign i_req.ready = (r_state == tmw_pkg::S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_load    = (r_state == tmw_pkg::S_RESP) && (!r_ov || o_rsp.ready);

    assign rd_in_range = (32'(i_req.read_row) < ROWS) && (32'(i_req.read_col) < COLUMNS);
    assign col_last    = (r_cur_col == COL_W'(COLUMNS - 1));
    assign row_last    = (r_cur_row == ROW_W'(ROWS - 1));
    assign cur_lin     = 32'(r_cur_row) * COLUMNS + 32'(r_cur_col);
    assign rd_lin      = 32'(i_req.read_row) * COLUMNS + 32'(i_req.read_col);
    assign cur_addr    = cur_lin[ADDR_W-1:0];
    assign rd_addr     = rd_lin[ADDR_W-1:0];

    // cursor fields are masked or zero-extended to the port widths
    assign row_ext = {5'b0, r_cur_row};
    assign col_ext = {7'b0, r_cur_col};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmw_pkg::S_INIT: begin
                if (r_cnt == CNT_W'(CELLS - 1)) n_state = tmw_pkg::S_IDLE;
            end
            tmw_pkg::S_IDLE: begin
                if (req_acc) begin
                    case (i_req.func)
                        tmw_pkg::FUNC_PUT:
                            n_state = (col_last && row_last) ? tmw_pkg::S_SCROLL
                                                             : tmw_pkg::S_RESP;
                        tmw_pkg::FUNC_CLEAR: n_state = tmw_pkg::S_FILL;
                        tmw_pkg::FUNC_READ:
                            n_state = rd_in_range ? tmw_pkg::S_READ : tmw_pkg::S_RESP;
                        default: n_state = tmw_pkg::S_RESP;
                    endcase
                end
            end
            tmw_pkg::S_READ:   n_state = tmw_pkg::S_RESP;
            tmw_pkg::S_SCROLL: begin
                if (r_cnt == CNT_W'(SCROLL_N)) n_state = tmw_pkg::S_FILL;
            end
            tmw_pkg::S_FILL: begin
                if (r_cnt == CNT_W'(CELLS - 1)) n_state = tmw_pkg::S_RESP;
            end
            tmw_pkg::S_RESP: begin
                if (out_load) n_state = tmw_pkg::S_IDLE;
            end
            default: n_state = tmw_pkg::S_IDLE;
        endcase
    end

    // memory controls, counter, cursor and result
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        n_cnt      = r_cnt;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_res_scr  = r_res_scr;
        n_res_cell = r_res_cell;
        case (r_state)
            tmw_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[ADDR_W-1:0];
                mem_wdata = tmw_pkg::RESET_CELL;
                n_cnt     = r_cnt + CNT_W'(1);
            end
            tmw_pkg::S_IDLE: begin
                mem_raddr = rd_addr;
                if (req_acc) begin
                    n_res_scr  = 1'b0;
                    n_res_cell = '0;
                    case (i_req.func)
                        tmw_pkg::FUNC_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr;
                            mem_wdata = {r_color, i_req.char_code};
                            if (col_last) begin
                                n_cur_col = '0;
                                if (row_last) begin
                                    n_res_scr = 1'b1;
                                    n_cnt     = '0;
                                end else begin
                                    n_cur_row = r_cur_row + ROW_W'(1);
                                end
                            end else begin
                                n_cur_col = r_cur_col + COL_W'(1);
                            end
                        end
                        tmw_pkg::FUNC_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_cnt     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            tmw_pkg::S_READ: n_res_cell = r_rdata;
            tmw_pkg::S_SCROLL: begin
                // read one row ahead, write the data back in the next cycle
                mem_raddr = ADDR_W'(r_cnt + CNT_W'(COLUMNS));
                mem_we    = (r_cnt != '0);
                mem_waddr = ADDR_W'(r_cnt - CNT_W'(1));
                mem_wdata = r_rdata;
                if (r_cnt != CNT_W'(SCROLL_N)) n_cnt = r_cnt + CNT_W'(1);
            end
            tmw_pkg::S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[ADDR_W-1:0];
                mem_wdata = {r_color, tmw_pkg::SPACE_CHAR};
                n_cnt     = r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tmw_pkg::S_INIT;
            r_cnt     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_color   <= 8'h07;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            if (i_cfg_wr_en) r_color <= i_cfg_wr_data;
            if (out_load)          r_ov <= 1'b1;
            else if (o_rsp.ready)  r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_scr  <= n_res_scr;
        r_res_cell <= n_res_cell;
        if (out_load) begin
            r_o_row  <= row_ext[4:0];
            r_o_col  <= col_ext[6:0];
            r_o_scr  <= r_res_scr;
            r_o_cell <= r_res_cell;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.cursor_row = r_o_row;
    assign o_rsp.cursor_col = r_o_col;
    assign o_rsp.scrolled   = r_o_scr;
    assign o_rsp.cell_word  = r_o_cell;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) < ROWS) && (32'(r_cur_col) < COLUMNS))
        else $error("cursor out of screen");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < CELLS))
        else $error("screen write beyond last cell");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_rsp.scrolled) |->
            (r_o_col == 7'd0) && (32'(r_o_row) == ((ROWS - 1) & 31)))
        else $error("scroll response with cursor off the last row start");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != tmw_pkg::S_IDLE))
        else $error("request taken without any work");
`endif

endmodule
